@@ hw/rtl/scheme_token_lexer_macros.svh @@
// ----------------------------------------------------------------------------
// Scheme token lexer assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef SCHEME_TOKEN_LEXER_MACROS_SVH
`define SCHEME_TOKEN_LEXER_MACROS_SVH

// same-cycle implication
`define STL_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define STL_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/stl_pkg.sv @@
// ----------------------------------------------------------------------------
// stl_pkg
// Types and constants shared by the Scheme token lexer modules.
// ----------------------------------------------------------------------------
`default_nettype none

package stl_pkg;

    // lexer modes
    localparam logic [2:0] M_IDLE = 3'd0;
    localparam logic [2:0] M_SIGN = 3'd1;
    localparam logic [2:0] M_DOT  = 3'd2;
    localparam logic [2:0] M_NUM  = 3'd3;
    localparam logic [2:0] M_ATOM = 3'd4;
    localparam logic [2:0] M_STR  = 3'd5;
    localparam logic [2:0] M_ERR  = 3'd6;

    // token types
    localparam logic [3:0] TT_END      = 4'd0;
    localparam logic [3:0] TT_INT      = 4'd1;
    localparam logic [3:0] TT_FLOAT    = 4'd2;
    localparam logic [3:0] TT_STRING   = 4'd3;
    localparam logic [3:0] TT_ATOM     = 4'd4;
    localparam logic [3:0] TT_DOT      = 4'd5;
    localparam logic [3:0] TT_LPAREN   = 4'd6;
    localparam logic [3:0] TT_RPAREN   = 4'd7;
    localparam logic [3:0] TT_LBRACKET = 4'd8;
    localparam logic [3:0] TT_RBRACKET = 4'd9;
    localparam logic [3:0] TT_ERROR    = 4'd10;

    // error codes
    localparam logic [2:0] E_NONE     = 3'd0;
    localparam logic [2:0] E_TOO_LONG = 3'd1;
    localparam logic [2:0] E_DOT_EXP  = 3'd2;
    localparam logic [2:0] E_EXP_NODG = 3'd3;
    localparam logic [2:0] E_ATOM_CH  = 3'd4;
    localparam logic [2:0] E_UNTERM   = 3'd5;

    // characters
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_E_UP   = 8'h45;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_E_LO   = 8'h65;

    localparam logic [5:0] MAX_LEN_RESET = 6'd32;

    // what one accepted word will emit
    typedef struct packed {
        logic       s0_en;     // dot token ahead of the rest
        logic       txt_en;    // buffered text
        logic [3:0] txt_type;
        logic       s1_en;     // bracket, dot or error token
        logic [3:0] s1_type;
        logic       s1_has;
        logic [7:0] s1_char;
        logic [2:0] s1_err;
        logic       s2_en;     // end token
    } stl_plan_t;

    // text cell writes
    typedef struct packed {
        logic       a_en;
        logic [7:0] a_data;
        logic       b_en;      // second char into cell 1
    } stl_wr_t;

    typedef struct packed {
        logic [3:0] token_type;
        logic       has_char;
        logic [7:0] text_char;
        logic       last_of_token;
        logic [2:0] error_code;
        logic       last_of_run;
    } stl_res_t;

endpackage

`default_nettype wire

@@ hw/rtl/stl_cell.sv @@
// ----------------------------------------------------------------------------
// stl_cell
// One character of the token text chain: load in place or shift to head.
// ----------------------------------------------------------------------------
`default_nettype none

module stl_cell (
    input  wire logic       clk,
    input  wire logic       ld,
    input  wire logic [7:0] ld_data,
    input  wire logic       shift,
    input  wire logic [7:0] shift_in,
    output logic      [7:0] q
);

    logic [7:0] q_reg;
    logic [7:0] q_next;

    always_comb
    begin
        q_next = q_reg;
        if (shift)
        begin
            q_next = shift_in;
        end
        else if (ld)
        begin
            q_next = ld_data;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
    end

    assign q = q_reg;

endmodule

`default_nettype wire

@@ hw/rtl/stl_lexer.sv @@
// ----------------------------------------------------------------------------
// stl_lexer
// Token state machine: classifies each word, drives cell writes and
// hands an emission plan to the sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module stl_lexer import stl_pkg::*; #(
    parameter int MAX_TOKEN = 32,
    parameter int LW        = $clog2(MAX_TOKEN + 1),
    parameter int IW        = $clog2(MAX_TOKEN)
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          cfg_we,
    input  wire logic [5:0]    cfg_wdata,
    input  wire logic          in_fire,
    input  wire logic [7:0]    ch,
    input  wire logic          end_of_input,
    output stl_plan_t          plan,
    output logic      [LW-1:0] txt_len,
    output stl_wr_t            wr,
    output logic      [IW-1:0] wr_idx
);

    logic [2:0]    mode_reg, mode_next;
    logic [LW-1:0] len_reg, len_next;
    logic          flt_reg, flt_next;
    logic          dig_reg, dig_next;
    logic          exp_reg, exp_next;
    logic [5:0]    max_len_reg;

    logic [LW-1:0] lim;
    logic          c_dig, c_e, c_space, c_term, c_sign;
    logic [3:0]    brk;
    stl_wr_t       wr_raw;

    assign lim = (max_len_reg > 6'(MAX_TOKEN)) ? LW'(MAX_TOKEN) : LW'(max_len_reg);

    assign c_dig   = (ch >= CH_ZERO) && (ch <= CH_NINE);
    assign c_e     = (ch == CH_E_LO) || (ch == CH_E_UP);
    assign c_space = (ch == CH_SPACE) || ((ch >= CH_TAB) && (ch <= CH_CR));
    assign c_term  = (ch == CH_SPACE) || (ch == CH_LF) || (ch == CH_TAB)
                   || (ch == CH_RPAREN) || (ch == CH_RBRACK);
    assign c_sign  = (ch == CH_PLUS) || (ch == CH_MINUS);

    always_comb
    begin
        case (ch)
            CH_LPAREN: brk = TT_LPAREN;
            CH_RPAREN: brk = TT_RPAREN;
            CH_LBRACK: brk = TT_LBRACKET;
            CH_RBRACK: brk = TT_RBRACKET;
            default:   brk = TT_END;
        endcase
    end

    always_comb
    begin : p_next
        logic [LW-1:0] bl;
        logic          bf, bd, be;
        logic          do_num, do_atom, do_idle, do_app, do_close, fail_en;
        logic [2:0]    fail_code;
        logic [2:0]    app_mode;
        logic [3:0]    close_type;

        bl         = len_reg;
        bf         = flt_reg;
        bd         = dig_reg;
        be         = exp_reg;
        do_num     = 1'b0;
        do_atom    = 1'b0;
        do_idle    = 1'b0;
        do_app     = 1'b0;
        do_close   = 1'b0;
        fail_en    = 1'b0;
        fail_code  = E_NONE;
        app_mode   = M_IDLE;
        close_type = TT_ATOM;

        mode_next = mode_reg;
        len_next  = len_reg;
        flt_next  = flt_reg;
        dig_next  = dig_reg;
        exp_next  = exp_reg;
        plan      = '0;
        txt_len   = len_reg;
        wr_raw    = '0;
        wr_idx    = '0;

        if (end_of_input)
        begin
            case (mode_reg)
                M_SIGN, M_ATOM:
                begin
                    plan.txt_en   = 1'b1;
                    plan.txt_type = TT_ATOM;
                end
                M_NUM:
                begin
                    plan.txt_en   = 1'b1;
                    plan.txt_type = flt_reg ? TT_FLOAT : TT_INT;
                end
                M_DOT:
                begin
                    plan.s1_en   = 1'b1;
                    plan.s1_type = TT_DOT;
                    plan.s1_has  = 1'b1;
                    plan.s1_char = CH_DOT;
                end
                M_STR:
                begin
                    plan.s1_en   = 1'b1;
                    plan.s1_type = TT_ERROR;
                    plan.s1_err  = E_UNTERM;
                end
                default:
                begin
                end
            endcase
            plan.s2_en = 1'b1;
            mode_next  = M_IDLE;
            len_next   = '0;
            flt_next   = 1'b0;
            dig_next   = 1'b0;
            exp_next   = 1'b0;
        end
        else
        begin
            case (mode_reg)
                M_SIGN:
                begin
                    if ((ch == CH_DOT) || c_dig)
                    begin
                        do_num = 1'b1;
                    end
                    else
                    begin
                        do_atom = 1'b1;
                    end
                end
                M_DOT:
                begin
                    if (c_dig)
                    begin
                        if (lim < LW'(2))
                        begin
                            fail_en   = 1'b1;
                            fail_code = E_TOO_LONG;
                        end
                        else
                        begin
                            wr_raw.a_en   = 1'b1;
                            wr_raw.a_data = CH_DOT;
                            wr_raw.b_en   = 1'b1;
                            wr_idx        = '0;
                            mode_next     = M_NUM;
                            len_next      = LW'(2);
                            flt_next      = 1'b1;
                            dig_next      = 1'b1;
                            exp_next      = 1'b0;
                        end
                    end
                    else
                    begin
                        plan.s0_en = 1'b1;
                        mode_next  = M_IDLE;
                        do_idle    = 1'b1;
                    end
                end
                M_NUM:  do_num  = 1'b1;
                M_ATOM: do_atom = 1'b1;
                M_STR:
                begin
                    if (ch == CH_QUOTE)
                    begin
                        plan.txt_en   = 1'b1;
                        plan.txt_type = TT_STRING;
                        mode_next     = M_IDLE;
                        len_next      = '0;
                        flt_next      = 1'b0;
                        dig_next      = 1'b0;
                        exp_next      = 1'b0;
                    end
                    else
                    begin
                        do_app   = 1'b1;
                        app_mode = M_STR;
                    end
                end
                M_ERR:
                begin
                end
                default:
                begin
                    mode_next = M_IDLE;
                    do_idle   = 1'b1;
                end
            endcase

            if (do_idle && !c_space)
            begin
                bl       = '0;
                bf       = 1'b0;
                bd       = 1'b0;
                be       = 1'b0;
                len_next = '0;
                flt_next = 1'b0;
                dig_next = 1'b0;
                exp_next = 1'b0;
                if (c_sign)
                begin
                    do_app   = 1'b1;
                    app_mode = M_SIGN;
                end
                else if (c_dig)
                begin
                    do_num = 1'b1;
                end
                else if (ch == CH_QUOTE)
                begin
                    mode_next = M_STR;
                end
                else if (ch == CH_DOT)
                begin
                    mode_next = M_DOT;
                end
                else if (brk != TT_END)
                begin
                    plan.s1_en   = 1'b1;
                    plan.s1_type = brk;
                    plan.s1_has  = 1'b1;
                    plan.s1_char = ch;
                end
                else
                begin
                    do_atom = 1'b1;
                end
            end

            if (do_num)
            begin
                app_mode = M_NUM;
                if (c_term)
                begin
                    do_close   = 1'b1;
                    close_type = bf ? TT_FLOAT : TT_INT;
                end
                else if (ch == CH_DOT)
                begin
                    if (be)
                    begin
                        fail_en   = 1'b1;
                        fail_code = E_DOT_EXP;
                    end
                    else
                    begin
                        bf     = 1'b1;
                        do_app = 1'b1;
                    end
                end
                else if (c_e)
                begin
                    if (!bd)
                    begin
                        fail_en   = 1'b1;
                        fail_code = E_EXP_NODG;
                    end
                    else
                    begin
                        bf     = 1'b1;
                        be     = 1'b1;
                        do_app = 1'b1;
                    end
                end
                else
                begin
                    if (c_dig)
                    begin
                        bd = 1'b1;
                    end
                    do_app = 1'b1;
                end
            end

            if (do_atom)
            begin
                app_mode = M_ATOM;
                if (c_term)
                begin
                    do_close   = 1'b1;
                    close_type = TT_ATOM;
                end
                else if ((ch == CH_LPAREN) || (ch == CH_LBRACK) || (ch == CH_DOT)
                         || (ch == CH_QUOTE))
                begin
                    fail_en   = 1'b1;
                    fail_code = E_ATOM_CH;
                end
                else
                begin
                    do_app = 1'b1;
                end
            end

            if (do_close)
            begin
                plan.txt_en   = 1'b1;
                plan.txt_type = close_type;
                txt_len       = bl;
                if (brk != TT_END)
                begin
                    plan.s1_en   = 1'b1;
                    plan.s1_type = brk;
                    plan.s1_has  = 1'b1;
                    plan.s1_char = ch;
                end
                mode_next = M_IDLE;
                len_next  = '0;
                flt_next  = 1'b0;
                dig_next  = 1'b0;
                exp_next  = 1'b0;
            end

            if (do_app)
            begin
                if (bl >= lim)
                begin
                    fail_en   = 1'b1;
                    fail_code = E_TOO_LONG;
                end
                else
                begin
                    wr_raw.a_en   = 1'b1;
                    wr_raw.a_data = ch;
                    wr_idx        = bl[IW-1:0];
                    mode_next     = app_mode;
                    len_next      = bl + LW'(1);
                    flt_next      = bf;
                    dig_next      = bd;
                    exp_next      = be;
                end
            end

            if (fail_en)
            begin
                plan.s1_en   = 1'b1;
                plan.s1_type = TT_ERROR;
                plan.s1_has  = 1'b0;
                plan.s1_char = '0;
                plan.s1_err  = fail_code;
                wr_raw       = '0;
                mode_next    = M_ERR;
                len_next     = '0;
                flt_next     = 1'b0;
                dig_next     = 1'b0;
                exp_next     = 1'b0;
            end
        end
    end

    assign wr = in_fire ? wr_raw : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= M_IDLE;
            len_reg     <= '0;
            flt_reg     <= 1'b0;
            dig_reg     <= 1'b0;
            exp_reg     <= 1'b0;
            max_len_reg <= MAX_LEN_RESET;
        end
        else
        begin
            if (in_fire)
            begin
                mode_reg <= mode_next;
                len_reg  <= len_next;
                flt_reg  <= flt_next;
                dig_reg  <= dig_next;
                exp_reg  <= exp_next;
            end
            if (cfg_we)
            begin
                max_len_reg <= cfg_wdata;
            end
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/stl_emit.sv @@
// ----------------------------------------------------------------------------
// stl_emit
// Result sequencer: walks the plan of one word, drains the text chain one
// character per result and holds the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module stl_emit import stl_pkg::*; #(
    parameter int LW = 6
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_fire,
    input  stl_plan_t          plan,
    input  wire logic [LW-1:0] txt_len,
    input  wire logic [7:0]    head_char,
    input  wire logic          out_stall,
    output logic               busy,
    output logic               shift,
    output logic               out_valid,
    output stl_res_t           res
);

    localparam logic [2:0] PH_IDLE = 3'd0;
    localparam logic [2:0] PH_S0   = 3'd1;
    localparam logic [2:0] PH_TXT  = 3'd2;
    localparam logic [2:0] PH_S1   = 3'd3;
    localparam logic [2:0] PH_S2   = 3'd4;

    logic [2:0]    ph_reg, ph_next;
    stl_plan_t     plan_reg;
    logic [LW-1:0] cnt_reg, cnt_next;
    logic          ov_reg, ov_next;
    stl_res_t      res_reg, res_next;

    logic [2:0] first_s1, first_txt, first_ph;
    logic [2:0] after_s1, after_txt, after_s0;
    logic       fire;

    assign first_s1  = plan.s2_en ? PH_S2 : PH_IDLE;
    assign first_txt = plan.s1_en ? PH_S1 : first_s1;
    assign first_ph  = plan.s0_en ? PH_S0 : (plan.txt_en ? PH_TXT : first_txt);

    assign after_s1  = plan_reg.s2_en ? PH_S2 : PH_IDLE;
    assign after_txt = plan_reg.s1_en ? PH_S1 : after_s1;
    assign after_s0  = plan_reg.txt_en ? PH_TXT : after_txt;

    assign busy  = (ph_reg != PH_IDLE);
    assign fire  = busy && (!ov_reg || !out_stall);
    assign shift = fire && (ph_reg == PH_TXT) && (cnt_reg != '0);

    always_comb
    begin
        ph_next  = ph_reg;
        cnt_next = cnt_reg;
        res_next = res_reg;
        ov_next  = ov_reg && out_stall;

        if (in_fire)
        begin
            ph_next  = first_ph;
            cnt_next = txt_len;
        end
        else if (fire)
        begin
            ov_next                = 1'b1;
            res_next               = '0;
            res_next.last_of_token = 1'b1;
            case (ph_reg)
                PH_S0:
                begin
                    res_next.token_type = TT_DOT;
                    res_next.has_char   = 1'b1;
                    res_next.text_char  = CH_DOT;
                    ph_next             = after_s0;
                end
                PH_TXT:
                begin
                    res_next.token_type    = plan_reg.txt_type;
                    res_next.has_char      = (cnt_reg != '0);
                    res_next.text_char     = (cnt_reg != '0) ? head_char : 8'h00;
                    res_next.last_of_token = (cnt_reg <= LW'(1));
                    if (cnt_reg > LW'(1))
                    begin
                        ph_next = PH_TXT;
                    end
                    else
                    begin
                        ph_next = after_txt;
                    end
                    if (cnt_reg != '0)
                    begin
                        cnt_next = cnt_reg - LW'(1);
                    end
                end
                PH_S1:
                begin
                    res_next.token_type = plan_reg.s1_type;
                    res_next.has_char   = plan_reg.s1_has;
                    res_next.text_char  = plan_reg.s1_char;
                    res_next.error_code = plan_reg.s1_err;
                    ph_next             = after_s1;
                end
                PH_S2:
                begin
                    res_next.token_type = TT_END;
                    ph_next             = PH_IDLE;
                end
                default:
                begin
                    ph_next = PH_IDLE;
                end
            endcase
            res_next.last_of_run = (ph_next == PH_IDLE);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ph_reg <= PH_IDLE;
            ov_reg <= 1'b0;
        end
        else
        begin
            ph_reg <= ph_next;
            ov_reg <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            plan_reg <= plan;
        end
        cnt_reg <= cnt_next;
        res_reg <= res_next;
    end

    assign out_valid = ov_reg;
    assign res       = res_reg;

endmodule

`default_nettype wire

@@ hw/rtl/scheme_token_lexer.sv @@
// ----------------------------------------------------------------------------
// scheme_token_lexer
// Streaming Scheme tokeniser with a shifting chain of text cells.
// ----------------------------------------------------------------------------
// Input words carry one character (ch) or an end mark (end_of_input) on a
// valid/stall channel; a word is taken when in_valid is high and in_stall low.
// Each word yields zero or more result words on the output valid/stall
// channel, one field per port; last_of_run marks the final one of a word.
// A taken word loads the plan and phase registers; the sequencer then writes
// its first result into the output register. Results leave at one per cycle
// while out_stall is low; a word causing results stalls the input until
// the last result is loaded; one causing none does not. Token text is drained
// from the head of the cell chain, one cell shift per character.
// out_stall freezes a valid output register and the sequencer; nothing is lost.
// max_token_len must be written via cfg_we/cfg_wdata while the block is idle;
// the block does not enforce it. Reset returns the lexer to idle with an
// empty token and sets max_token_len to 32; the text cells need no clearing.
// ----------------------------------------------------------------------------
`default_nettype none

`include "scheme_token_lexer_macros.svh"

module scheme_token_lexer import stl_pkg::*; #(
    parameter int MAX_TOKEN = 32
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_we,
    input  wire logic [5:0] cfg_wdata,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [7:0] ch,
    input  wire logic       end_of_input,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic      [3:0] token_type,
    output logic            has_char,
    output logic      [7:0] text_char,
    output logic            last_of_token,
    output logic      [2:0] error_code,
    output logic            last_of_run
);

    localparam int LW = $clog2(MAX_TOKEN + 1);
    localparam int IW = $clog2(MAX_TOKEN);

    logic          in_fire;
    logic          busy;
    logic          shift;
    stl_plan_t     plan;
    logic [LW-1:0] txt_len;
    stl_wr_t       wr;
    logic [IW-1:0] wr_idx;
    stl_res_t      res;
    logic [7:0]    cell_q [MAX_TOKEN];
    logic          err_tok;
    logic          end_tok;

    assign in_stall = busy;
    assign in_fire  = in_valid && !busy;

    stl_lexer #(
        .MAX_TOKEN (MAX_TOKEN),
        .LW        (LW),
        .IW        (IW)
    ) u_lexer (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .in_fire      (in_fire),
        .ch           (ch),
        .end_of_input (end_of_input),
        .plan         (plan),
        .txt_len      (txt_len),
        .wr           (wr),
        .wr_idx       (wr_idx)
    );

    for (genvar i = 0; i < MAX_TOKEN; i++)
    begin : g_cell
        logic       ld;
        logic       a_hit;
        logic [7:0] ld_data;
        logic [7:0] sin;

        assign a_hit   = wr.a_en && (wr_idx == IW'(i));
        assign ld      = a_hit || (wr.b_en && (i == 1));
        assign ld_data = a_hit ? wr.a_data : ch;

        if (i == MAX_TOKEN - 1)
        begin : g_tail
            assign sin = 8'h00;
        end
        else
        begin : g_link
            assign sin = cell_q[i + 1];
        end

        stl_cell u_cell (
            .clk      (clk),
            .ld       (ld),
            .ld_data  (ld_data),
            .shift    (shift),
            .shift_in (sin),
            .q        (cell_q[i])
        );
    end

    stl_emit #(
        .LW (LW)
    ) u_emit (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_fire   (in_fire),
        .plan      (plan),
        .txt_len   (txt_len),
        .head_char (cell_q[0]),
        .out_stall (out_stall),
        .busy      (busy),
        .shift     (shift),
        .out_valid (out_valid),
        .res       (res)
    );

    assign token_type    = res.token_type;
    assign has_char      = res.has_char;
    assign text_char     = res.text_char;
    assign last_of_token = res.last_of_token;
    assign error_code    = res.error_code;
    assign last_of_run   = res.last_of_run;

    assign err_tok = (token_type == TT_ERROR);
    assign end_tok = (token_type == TT_END);

    // an end mark always produces at least the end token
    `STL_ASSERT_NEXT(a_eoi_busy, in_fire && end_of_input, in_stall, "end mark gave no result")
    `STL_ASSERT_NOW(a_err_code, out_valid, err_tok == (error_code != E_NONE), "bad error code")
    `STL_ASSERT_NOW(a_no_char, out_valid && !has_char, text_char == 8'h00, "stray text char")
    `STL_ASSERT_NOW(a_end_last, out_valid && end_tok, last_of_run && last_of_token, "end not last")

endmodule

`default_nettype wire

@@ tb/sv/testbench.sv @@
// ----------------------------------------------------------------------------
// Scheme token lexer testbench
// Feeds character words and end marks to the lexer on the valid/stall channel,
// with random gaps on input and random stalls on output, predicts every
// token word in a behavioural lexer kept beside the block and compares the
// results field by field. Directed token and error cases come first, then
// random lines of mostly well-formed tokens under several length limits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
    import stl_pkg::*;

    localparam int          TOKEN_CAP   = 32;
    localparam int          CYCLE_LIMIT = 2000000;
    localparam logic [7:0]  CH_VT       = 8'h0B;
    localparam logic [7:0]  CH_FF       = 8'h0C;

    logic       clk          = 1'b0;
    logic       rst_n        = 1'b0;
    logic       cfg_we       = 1'b0;
    logic [5:0] cfg_wdata    = 6'd0;
    logic       in_valid     = 1'b0;
    logic       in_stall;
    logic [7:0] ch           = 8'd0;
    logic       end_of_input = 1'b0;
    logic       out_valid;
    logic       out_stall    = 1'b0;
    logic [3:0] token_type;
    logic       has_char;
    logic [7:0] text_char;
    logic       last_of_token;
    logic [2:0] error_code;
    logic       last_of_run;

    // lexer state mirrored for prediction
    logic [2:0] lx_mode     = M_IDLE;
    logic [7:0] lx_text [TOKEN_CAP];
    int         lx_len      = 0;
    bit         lx_float    = 1'b0;
    bit         lx_digit    = 1'b0;
    bit         lx_exp      = 1'b0;
    logic [5:0] lx_limit    = MAX_LEN_RESET;

    stl_res_t   run_tokens[$];
    stl_res_t   expected_tokens[$];
    logic [7:0] line_q[$];

    bit steady      = 1'b0;
    int words_sent  = 0;
    int mismatches  = 0;
    int cycle_count = 0;

    scheme_token_lexer u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .ch            (ch),
        .end_of_input  (end_of_input),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .token_type    (token_type),
        .has_char      (has_char),
        .text_char     (text_char),
        .last_of_token (last_of_token),
        .error_code    (error_code),
        .last_of_run   (last_of_run)
    );

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: timeout", $time);
            $display("CHECK FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------
    function automatic bit is_digit(logic [7:0] c);
        return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    function automatic bit is_term(logic [7:0] c);
        return c == CH_SPACE || c == CH_LF || c == CH_TAB || c == CH_RPAREN || c == CH_RBRACK;
    endfunction

    function automatic bit is_space(logic [7:0] c);
        return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic logic [3:0] bracket_of(logic [7:0] c);
        case (c)
            CH_LPAREN: return TT_LPAREN;
            CH_RPAREN: return TT_RPAREN;
            CH_LBRACK: return TT_LBRACKET;
            CH_RBRACK: return TT_RBRACKET;
            default:   return TT_END;
        endcase
    endfunction

    function automatic void tok_put(logic [3:0] t, bit has, logic [7:0] c, bit last,
                                    logic [2:0] e);
        stl_res_t r;
        r.token_type    = t;
        r.has_char      = has;
        r.text_char     = has ? c : 8'd0;
        r.last_of_token = last;
        r.error_code    = e;
        r.last_of_run   = 1'b0;
        run_tokens.push_back(r);
    endfunction

    function automatic void tok_clear();
        lx_len   = 0;
        lx_float = 1'b0;
        lx_digit = 1'b0;
        lx_exp   = 1'b0;
    endfunction

    function automatic void tok_fail(logic [2:0] code);
        tok_put(TT_ERROR, 1'b0, 8'd0, 1'b1, code);
        lx_mode = M_ERR;
        tok_clear();
    endfunction

    function automatic bit tok_append(logic [7:0] c);
        int lim;
        lim = (lx_limit > TOKEN_CAP) ? TOKEN_CAP : int'(lx_limit);
        if (lx_len >= lim)
        begin
            tok_fail(E_TOO_LONG);
            return 1'b0;
        end
        lx_text[lx_len] = c;
        lx_len++;
        return 1'b1;
    endfunction

    function automatic void tok_emit_text(logic [3:0] t);
        if (lx_len == 0)
        begin
            tok_put(t, 1'b0, 8'd0, 1'b1, E_NONE);
            return;
        end
        for (int i = 0; i < lx_len; i++)
            tok_put(t, 1'b1, lx_text[i], i + 1 == lx_len, E_NONE);
    endfunction

    function automatic void tok_close(logic [3:0] t, logic [7:0] c);
        logic [3:0] b;
        tok_emit_text(t);
        b = bracket_of(c);
        if (b != TT_END)
            tok_put(b, 1'b1, c, 1'b1, E_NONE);
        lx_mode = M_IDLE;
        tok_clear();
    endfunction

    function automatic void lex_number(logic [7:0] c);
        if (is_term(c))
        begin
            tok_close(lx_float ? TT_FLOAT : TT_INT, c);
            return;
        end
        if (c == CH_DOT)
        begin
            if (lx_exp)
            begin
                tok_fail(E_DOT_EXP);
                return;
            end
            lx_float = 1'b1;
        end
        else if (c == CH_E_LO || c == CH_E_UP)
        begin
            if (!lx_digit)
            begin
                tok_fail(E_EXP_NODG);
                return;
            end
            lx_float = 1'b1;
            lx_exp   = 1'b1;
        end
        else if (is_digit(c))
            lx_digit = 1'b1;
        void'(tok_append(c));
    endfunction

    function automatic void lex_atom(logic [7:0] c);
        if (is_term(c))
        begin
            tok_close(TT_ATOM, c);
            return;
        end
        if (c == CH_LPAREN || c == CH_LBRACK || c == CH_DOT || c == CH_QUOTE)
        begin
            tok_fail(E_ATOM_CH);
            return;
        end
        void'(tok_append(c));
    endfunction

    function automatic void lex_idle(logic [7:0] c);
        logic [3:0] b;
        if (is_space(c))
            return;
        tok_clear();
        b = bracket_of(c);
        if (c == CH_PLUS || c == CH_MINUS)
        begin
            if (tok_append(c))
                lx_mode = M_SIGN;
        end
        else if (is_digit(c))
        begin
            lx_mode = M_NUM;
            lex_number(c);
        end
        else if (c == CH_QUOTE)
            lx_mode = M_STR;
        else if (c == CH_DOT)
            lx_mode = M_DOT;
        else if (b != TT_END)
            tok_put(b, 1'b1, c, 1'b1, E_NONE);
        else
        begin
            lx_mode = M_ATOM;
            lex_atom(c);
        end
    endfunction

    // results caused by one accepted word, appended to expected_tokens
    function automatic void lex_word(logic [7:0] c, bit eoi);
        if (eoi)
        begin
            case (lx_mode)
                M_SIGN, M_ATOM: tok_emit_text(TT_ATOM);
                M_NUM:          tok_emit_text(lx_float ? TT_FLOAT : TT_INT);
                M_DOT:          tok_put(TT_DOT, 1'b1, CH_DOT, 1'b1, E_NONE);
                M_STR:          tok_put(TT_ERROR, 1'b0, 8'd0, 1'b1, E_UNTERM);
                default:        ;
            endcase
            tok_put(TT_END, 1'b0, 8'd0, 1'b1, E_NONE);
            lx_mode = M_IDLE;
            tok_clear();
        end
        else
        begin
            case (lx_mode)
                M_SIGN:
                begin
                    if (c == CH_DOT || is_digit(c))
                    begin
                        lx_mode = M_NUM;
                        lex_number(c);
                    end
                    else
                    begin
                        lx_mode = M_ATOM;
                        lex_atom(c);
                    end
                end
                M_DOT:
                begin
                    if (is_digit(c))
                    begin
                        tok_clear();
                        lx_mode = M_NUM;
                        lex_number(CH_DOT);
                        if (lx_mode == M_NUM)
                            lex_number(c);
                    end
                    else
                    begin
                        tok_put(TT_DOT, 1'b1, CH_DOT, 1'b1, E_NONE);
                        lx_mode = M_IDLE;
                        lex_idle(c);
                    end
                end
                M_NUM:  lex_number(c);
                M_ATOM: lex_atom(c);
                M_STR:
                begin
                    if (c == CH_QUOTE)
                    begin
                        tok_emit_text(TT_STRING);
                        lx_mode = M_IDLE;
                        tok_clear();
                    end
                    else
                        void'(tok_append(c));
                end
                M_ERR:  ;
                default:
                begin
                    lx_mode = M_IDLE;
                    lex_idle(c);
                end
            endcase
        end
        if (run_tokens.size() > 0)
            run_tokens[run_tokens.size() - 1].last_of_run = 1'b1;
        foreach (run_tokens[i])
            expected_tokens.push_back(run_tokens[i]);
        run_tokens.delete();
    endfunction

    // ------------------------------------------------------------------
    // checking
    // ------------------------------------------------------------------
    function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge clk)
    begin : result_check
        stl_res_t want;
        if (rst_n && out_valid === 1'b1 && out_stall === 1'b0)
        begin
            if (expected_tokens.size() == 0)
            begin
                $display("%0t: unexpected word, expected none, actual type %0h char %0h",
                         $time, token_type, text_char);
                mismatches++;
            end
            else
            begin
                want = expected_tokens.pop_front();
                check_field("token_type", 8'(want.token_type), 8'(token_type));
                check_field("has_char", 8'(want.has_char), 8'(has_char));
                check_field("text_char", want.text_char, text_char);
                check_field("last_of_token", 8'(want.last_of_token), 8'(last_of_token));
                check_field("error_code", 8'(want.error_code), 8'(error_code));
                check_field("last_of_run", 8'(want.last_of_run), 8'(last_of_run));
            end
        end
    end

    // ------------------------------------------------------------------
    // idling
    // ------------------------------------------------------------------
    function automatic int pick_gap(int zero_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r < zero_pct)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(15, 30);
    endfunction

    initial
    begin
        forever
        begin
            if (steady)
            begin
                out_stall <= 1'b0;
                @(posedge clk);
            end
            else
            begin
                out_stall <= 1'b0;
                repeat (pick_gap(0)) @(posedge clk);
                out_stall <= 1'b1;
                repeat (pick_gap(0)) @(posedge clk);
            end
        end
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    task automatic send_word(logic [7:0] c, bit eoi);
        int gap;
        gap = steady ? 0 : pick_gap(45);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        ch           <= c;
        end_of_input <= eoi;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        words_sent++;
        lex_word(c, eoi);
    endtask

    task automatic send_text(string s, bit with_end);
        for (int i = 0; i < s.len(); i++)
            send_word(s[i], 1'b0);
        if (with_end)
            send_word(8'($urandom_range(0, 255)), 1'b1);
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (expected_tokens.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_token_limit(logic [5:0] v);
        cfg_wdata <= v;
        cfg_we    <= 1'b1;
        @(posedge clk);
        cfg_we    <= 1'b0;
        lx_limit   = v;
        @(posedge clk);
    endtask

    function automatic void push_digits(int n);
        for (int i = 0; i < n; i++)
            line_q.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
    endfunction

    function automatic int pick_len(int lim);
        int r;
        r = $urandom_range(0, 99);
        if (r < 75)
            return $urandom_range(1, lim < 4 ? lim : 4);
        if (r < 90)
            return lim + $urandom_range(0, 1);
        return $urandom_range(1, lim + 1);
    endfunction

    // one line of random tokens closed by an end mark
    task automatic send_random_line(int lim);
        string      heads;
        string      frag;
        int         n;
        logic [7:0] c;
        heads = "abcxyzQ!?*<=>/_%&~^:";
        line_q.delete();
        repeat ($urandom_range(1, 5))
        begin
            case ($urandom_range(0, 9))
                0, 1:
                begin
                    if ($urandom_range(0, 2) == 0)
                        line_q.push_back($urandom_range(0, 1) ? CH_PLUS : CH_MINUS);
                    push_digits(pick_len(lim));
                end
                2, 3:
                begin
                    if ($urandom_range(0, 3) == 0)
                        line_q.push_back($urandom_range(0, 1) ? CH_PLUS : CH_MINUS);
                    push_digits($urandom_range(0, 2));
                    line_q.push_back(CH_DOT);
                    push_digits(pick_len(lim));
                    if ($urandom_range(0, 1))
                    begin
                        line_q.push_back($urandom_range(0, 1) ? CH_E_LO : CH_E_UP);
                        push_digits($urandom_range(1, 2));
                    end
                end
                4:
                begin
                    line_q.push_back(CH_QUOTE);
                    n = pick_len(lim) - 1;
                    for (int i = 0; i < n; i++)
                    begin
                        c = 8'($urandom_range(0, 255));
                        line_q.push_back(c == CH_QUOTE ? 8'h71 : c);
                    end
                    if ($urandom_range(0, 9) != 0)
                        line_q.push_back(CH_QUOTE);
                end
                5, 6:
                begin
                    line_q.push_back(heads[$urandom_range(0, heads.len() - 1)]);
                    n = pick_len(lim) - 1;
                    for (int i = 0; i < n; i++)
                    begin
                        c = 8'($urandom_range(0, 255));
                        if (is_term(c) || c == CH_LPAREN || c == CH_LBRACK || c == CH_DOT
                            || c == CH_QUOTE)
                            c = 8'(8'h61 + $urandom_range(0, 25));
                        line_q.push_back(c);
                    end
                end
                7:
                begin
                    case ($urandom_range(0, 6))
                        0: line_q.push_back(CH_LPAREN);
                        1: line_q.push_back(CH_RPAREN);
                        2: line_q.push_back(CH_LBRACK);
                        3: line_q.push_back(CH_RBRACK);
                        4: line_q.push_back(CH_DOT);
                        5: line_q.push_back(CH_PLUS);
                        default: line_q.push_back(CH_MINUS);
                    endcase
                end
                8:
                begin
                    case ($urandom_range(0, 4))
                        0: frag = "1e.";
                        1: frag = "-.e";
                        2: frag = "ab(";
                        3: frag = "x\"";
                        default: frag = "+.E5";
                    endcase
                    for (int i = 0; i < frag.len(); i++)
                        line_q.push_back(frag[i]);
                end
                default:
                begin
                    repeat ($urandom_range(1, 4))
                        line_q.push_back(8'($urandom_range(0, 255)));
                end
            endcase
            case ($urandom_range(0, 19))
                0, 1, 2, 3, 4, 5, 6, 7: line_q.push_back(CH_SPACE);
                8, 9:                   line_q.push_back(CH_TAB);
                10, 11:                 line_q.push_back(CH_LF);
                12, 13, 14:             line_q.push_back(CH_RPAREN);
                15, 16, 17:             line_q.push_back(CH_RBRACK);
                18:                     line_q.push_back(CH_CR);
                default:                ;
            endcase
        end
        foreach (line_q[i])
            send_word(line_q[i], 1'b0);
        send_word(8'($urandom_range(0, 255)), 1'b1);
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    task automatic test_token_kinds();
        send_word(CH_TAB, 1'b0);
        send_word(CH_VT, 1'b0);
        send_text("(+1 -.5e3).7 \"\"a]", 1'b1);
    endtask

    task automatic test_odd_bytes();
        send_text("[\"", 1'b0);
        send_word(8'h00, 1'b0);
        send_word(8'hFF, 1'b0);
        send_word(CH_QUOTE, 1'b0);
        send_word(CH_FF, 1'b0);
        send_word(CH_CR, 1'b0);
        send_text(". x", 1'b1);
    endtask

    task automatic test_error_cases();
        send_text("1e.", 1'b1);
        send_text("-.e", 1'b1);
        send_text("a(b", 1'b1);
        send_text("\"ab", 1'b1);
        send_text("+", 1'b1);
        send_text(".", 1'b1);
    endtask

    task automatic test_token_limit();
        wait_idle();
        set_token_limit(6'd1);
        send_text("12 ", 1'b1);
        send_text("\"\".5", 1'b1);
        wait_idle();
        set_token_limit(6'd32);
        for (int i = 0; i < 32; i++)
            send_word(8'(8'h61 + i % 26), 1'b0);
        send_word(CH_RPAREN, 1'b0);
    endtask

    task automatic test_random_streams();
        int limits[5];
        int start;
        limits = '{32, 1, 0, 0, 32};
        limits[2] = $urandom_range(2, 8);
        limits[3] = $urandom_range(9, 31);
        for (int p = 0; p < 5; p++)
        begin
            wait_idle();
            set_token_limit(6'(limits[p]));
            steady = (p == 4);
            start  = words_sent;
            while (words_sent - start < 16)
                send_random_line(limits[p]);
        end
        steady = 1'b0;
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_token_kinds();
        test_odd_bytes();
        test_error_cases();
        test_token_limit();
        test_random_streams();
        wait_idle();
        repeat (4) @(posedge clk);
        if (mismatches == 0 && expected_tokens.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
